FILE: rtl/core/fir_filter_q11_defines.svh
// Assertion macros for the fir_filter_q11 block.
// Used by files that carry concurrent checks; define ASSERT_OFF to drop them.
`ifndef FIR_FILTER_Q11_DEFINES_SVH
`define FIR_FILTER_Q11_DEFINES_SVH

`ifndef ASSERT_OFF
`define FIR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fir_filter_q11 check failed");
`define FIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fir_filter_q11 check failed");
`else
`define FIR_ASSERT_IMP(label, clk, rst, ante, cons)
`define FIR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/fir_q11_pkg.sv
// Shared types and constants for the fir_filter_q11 block.
// No dependencies.
package fir_q11_pkg;

  localparam int TapsDefault = 34;
  localparam int IdxW        = 6;
  localparam int DataW       = 16;
  localparam int AccW        = 32;

  localparam logic [IdxW-1:0] TapCountReset = 6'd34;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpFilter = 1'b1;

  // one tap read out of the tap memories, already zeroed where unwritten
  typedef struct packed {
    logic                    vld;
    logic signed [DataW-1:0] coef;
    logic signed [DataW-1:0] samp;
  } tap_rd_t;

endpackage

FILE: rtl/core/fir_q11_in_if.sv
// Input item channel: load a coefficient or filter a sample.
// Standalone; payload widths match fir_q11_pkg.
interface fir_q11_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [5:0]        coeff_index;
  logic signed [15:0] coeff_value;
  logic signed [15:0] sample;

  modport source (output valid, operation, coeff_index, coeff_value, sample, input ready);
  modport sink   (input valid, operation, coeff_index, coeff_value, sample, output ready);
endinterface

FILE: rtl/core/fir_q11_out_if.sv
// Result item channel carrying the raw Q11 filter sum.
// Standalone.
interface fir_q11_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_value;

  modport source (output valid, filtered_value, input ready);
  modport sink   (input valid, filtered_value, output ready);
endinterface

FILE: rtl/core/fir_q11_cfg_if.sv
// Configuration write channel for the tap_count register.
// Standalone.
interface fir_q11_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] tap_count;

  modport source (output valid, tap_count, input ready);
  modport sink   (input valid, tap_count, output ready);
endinterface

FILE: rtl/core/fir_q11_tapmem.sv
// Coefficient memory and circular sample memory with registered reads.
// Depends on fir_q11_pkg.
module fir_q11_tapmem #(
  parameter  int TAPS = fir_q11_pkg::TapsDefault,
  localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1,
  localparam int KW   = $clog2(TAPS + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    coef_we,
  input  logic [fir_q11_pkg::IdxW-1:0]            coef_idx,
  input  logic signed [fir_q11_pkg::DataW-1:0]    coef_val,
  input  logic                                    samp_we,
  input  logic signed [fir_q11_pkg::DataW-1:0]    samp_val,
  input  logic                                    rd_en,
  input  logic [KW-1:0]                           rd_k,
  output fir_q11_pkg::tap_rd_t                    rd
);
  import fir_q11_pkg::*;

  localparam logic [AW-1:0] LastAddr = AW'(TAPS - 1);
  localparam logic [KW-1:0] FullCnt  = KW'(TAPS);

  logic signed [DataW-1:0] coef_mem [TAPS];
  logic signed [DataW-1:0] samp_mem [TAPS];
  logic [TAPS-1:0]         coef_vld;
  logic [AW-1:0]           head;
  logic [AW-1:0]           rptr;
  logic [KW-1:0]           fill;
  logic                    rd_vld;
  logic                    coef_ok;
  logic                    samp_ok;
  logic signed [DataW-1:0] coef_q;
  logic signed [DataW-1:0] samp_q;
  logic [AW-1:0]           head_inc;
  logic [AW-1:0]           rptr_dec;
  logic                    coef_hit;

  assign head_inc = (head == LastAddr) ? '0 : head + 1'b1;
  assign rptr_dec = (rptr == '0) ? LastAddr : rptr - 1'b1;
  // indexes at or past the table depth are dropped
  assign coef_hit = coef_we && ({1'b0, coef_idx} < 7'(TAPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      head     <= '0;
      rptr     <= '0;
      fill     <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (coef_hit) begin
        coef_vld[coef_idx[AW-1:0]] <= 1'b1;
      end
      if (samp_we) begin
        head <= head_inc;
        rptr <= head_inc;
        if (fill != FullCnt) begin
          fill <= fill + 1'b1;
        end
      end else if (rd_en) begin
        rptr <= rptr_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (coef_hit) begin
      coef_mem[coef_idx[AW-1:0]] <= coef_val;
    end
    if (samp_we) begin
      samp_mem[head_inc] <= samp_val;
    end
    if (rd_en) begin
      coef_q  <= coef_mem[rd_k[AW-1:0]];
      samp_q  <= samp_mem[rptr];
      coef_ok <= coef_vld[rd_k[AW-1:0]];
      // taps older than the samples seen since reset read as zero
      samp_ok <= rd_k < fill;
    end
  end

  assign rd.vld  = rd_vld;
  assign rd.coef = coef_ok ? coef_q : '0;
  assign rd.samp = samp_ok ? samp_q : '0;

endmodule

FILE: rtl/core/fir_q11_mac.sv
// Shared multiply-accumulate: registered 16x16 product, 32-bit wrapping sum.
// Depends on fir_q11_pkg.
module fir_q11_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  fir_q11_pkg::tap_rd_t                 rd,
  output logic signed [fir_q11_pkg::AccW-1:0]  acc,
  output logic                                 busy
);
  import fir_q11_pkg::*;

  logic signed [AccW-1:0] prod;
  logic signed [AccW-1:0] prod_next;
  logic                   prod_vld;
  logic signed [AccW-1:0] coef_ext;
  logic signed [AccW-1:0] samp_ext;

  // sign-extend both operands so the low 32 bits of the product are exact
  assign coef_ext  = {{(AccW-DataW){rd.coef[DataW-1]}}, rd.coef};
  assign samp_ext  = {{(AccW-DataW){rd.samp[DataW-1]}}, rd.samp};
  assign prod_next = coef_ext * samp_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= rd.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.vld) begin
      prod <= prod_next;
    end
    if (clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  assign busy = prod_vld;

endmodule

FILE: rtl/core/fir_filter_q11.sv
// Top level of the direct-form Q11 FIR filter.
// Depends on fir_q11_pkg, the channel interfaces, fir_q11_tapmem and fir_q11_mac.

// A load item writes one coefficient and gives no result. A sample item
// shifts into the delay line and then holds off the input until its result
// has been handed to the result register. One shared 16x16
// multiply-accumulate walks the active taps one per cycle, fed by single-port
// coefficient and sample memories with registered reads, followed by a
// pipeline drain through the read, product and accumulator registers and a
// hand-off to the result register, which also waits while an earlier result
// is still untaken. The result is the raw Q11 sum in a 32-bit accumulator
// that wraps. A finished result waits in its own register, so a new item
// may be accepted before it is taken. tap_count above TAPS acts as TAPS;
// zero gives a result of zero.
`include "fir_filter_q11_defines.svh"

module fir_filter_q11 #(
  parameter  int TAPS = fir_q11_pkg::TapsDefault
) (
  input  logic          clk,
  input  logic          rst,
  fir_q11_in_if.sink    din,
  fir_q11_out_if.source dout,
  fir_q11_cfg_if.sink   cfg
);
  import fir_q11_pkg::*;

  localparam int KW = $clog2(TAPS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                 state;
  logic [KW-1:0]          k;
  logic [KW-1:0]          active;
  logic [IdxW-1:0]        tap_count;
  logic                   out_vld;
  logic signed [AccW-1:0] out_data;
  logic [6:0]             act_full;
  logic                   in_acc;
  logic                   coef_we;
  logic                   samp_we;
  logic                   rd_en;
  logic                   out_load;
  logic                   mac_busy;
  logic signed [AccW-1:0] acc;
  tap_rd_t                rd;

  assign din.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign in_acc    = din.valid && din.ready;
  assign coef_we   = in_acc && (din.operation == OpLoad);
  assign samp_we   = in_acc && (din.operation == OpFilter);
  assign act_full  = ({1'b0, tap_count} > 7'(TAPS)) ? 7'(TAPS) : {1'b0, tap_count};
  assign rd_en     = (state == S_RUN) && (k < active);
  assign out_load  = (state == S_DONE) && (!out_vld || dout.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TapCountReset;
    end else if (cfg.valid && cfg.ready) begin
      tap_count <= cfg.tap_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      k       <= '0;
      active  <= '0;
      out_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (samp_we) begin
            state  <= S_RUN;
            k      <= '0;
            active <= KW'(act_full);
          end
        end
        S_RUN: begin
          if (rd_en) begin
            k <= k + 1'b1;
          end else if (!rd.vld && !mac_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (dout.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= acc;
    end
  end

  assign dout.valid          = out_vld;
  assign dout.filtered_value = out_data;

  fir_q11_tapmem #(
    .TAPS(TAPS)
  ) u_tapmem (
    .clk      (clk),
    .rst      (rst),
    .coef_we  (coef_we),
    .coef_idx (din.coeff_index),
    .coef_val (din.coeff_value),
    .samp_we  (samp_we),
    .samp_val (din.sample),
    .rd_en    (rd_en),
    .rd_k     (k),
    .rd       (rd)
  );

  fir_q11_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (samp_we),
    .rd    (rd),
    .acc   (acc),
    .busy  (mac_busy)
  );

  `FIR_ASSERT_NEXT(a_filter_holds_off, clk, rst, samp_we, !din.ready)
  `FIR_ASSERT_IMP(a_tap_walk_bound, clk, rst, state == S_RUN, k <= active)
  `FIR_ASSERT_IMP(a_result_drained, clk, rst, out_load, !rd.vld && !mac_busy)

endmodule
